// ===== sv/oigo_pkg.sv =====
// Package for the occupancy grid inflation core: field widths, register
// indexes, controller states and the command/status structs.
// No dependencies.
`default_nettype none

package oigo_pkg;

    // Field and internal widths
    localparam int DIM_W   = 9;   // image width / height register
    localparam int RAD_W   = 4;   // inflate radius register
    localparam int CSZ_W   = 5;   // cell size register
    localparam int CELL_W  = 8;   // cell_row / cell_col
    localparam int PIX_W   = 8;   // color channel
    localparam int COORD_W = 13;  // cell_row * cell_size + cell_size
    localparam int FLAG_W  = 2;
    localparam int CFG_W   = 9;   // widest register
    localparam int IDX_W   = 2;

    // Flag bit positions
    localparam int FLAG_BLACK   = 0;
    localparam int FLAG_NOT_RED = 1;

    // Color and size limits
    localparam logic [PIX_W-1:0] RED_FULL = 8'd255;
    localparam logic [CSZ_W-1:0] CELL_MAX = 5'd16;

    // Default storage bounds
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Register reset values
    localparam logic [DIM_W-1:0] RST_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 9'd256;
    localparam logic [RAD_W-1:0] RST_RADIUS = 4'd0;
    localparam logic [CSZ_W-1:0] RST_CSIZE  = 5'd4;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_INFLATE_RADIUS = 2'd2,
        REG_CELL_SIZE      = 2'd3
    } reg_idx_t;

    // Input commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUND,
        S_WIN,
        S_BASE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_pix;     // write the accepted pixel's flags
        logic start_query;  // capture cell origin, clear occupancy
        logic bound;        // cell bounds, empty check
        logic win;          // inflated window bounds
        logic base;         // first row base address
        logic scan;         // issue one read of the window
        logic push;         // move result to output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;        // cell lies wholly outside the image
        logic scan_last;    // current read is the window's last
        logic out_free;     // output register can take a beat
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/obstacle_inflate_grid_occupancy_core.sv =====
// Top level of the occupancy grid core with square obstacle inflation.
// Depends on oigo_pkg, oigo_ctrl, oigo_dp (which holds oigo_ram).
//
//  channel  ports                                   direction  use
//  s_       valid/ready, command, red, green, blue,  in         pixel load or cell query
//           cell_row, cell_col
//  m_       valid/ready, occupied                    out        one beat per query
//  cfg_     wr_en, index, wr_data                    in         register writes
//
// Pixel loads are accepted back to back while idle. A query steps through
// bound, window and base, then scans the cell window grown by the radius and
// clipped to the image, one flag memory read per cycle, then drain and done;
// a cell wholly outside the image skips base, scan and drain.
// Reset clears control, load position and registers; the flag memory has no
// clearing pass and is undefined until loaded.
// A result waiting on m_ready holds the next query in its done state only;
// loads keep flowing meanwhile.
`default_nettype none

module obstacle_inflate_grid_occupancy_core
    import oigo_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_command,
    input  wire logic [PIX_W-1:0]   s_red,
    input  wire logic [PIX_W-1:0]   s_green,
    input  wire logic [PIX_W-1:0]   s_blue,
    input  wire logic [CELL_W-1:0]  s_cell_row,
    input  wire logic [CELL_W-1:0]  s_cell_col,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_occupied,
    input  wire logic               cfg_wr_en,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wr_data
);

    cmd_t  cmd;
    stat_t stat;

    oigo_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    oigo_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_cell_row  (s_cell_row),
        .s_cell_col  (s_cell_col),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_occupied  (m_occupied)
    );

endmodule

`default_nettype wire

// ===== sv/oigo_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module oigo_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/oigo_ctrl.sv =====
// Controller state machine: pixel loads in idle, query sequencing through
// bound, window, base, scan, drain and result. Uses oigo_pkg.
`default_nettype none

module oigo_ctrl
    import oigo_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    input  wire logic  s_command,
    output logic       s_ready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_command == CMD_QUERY) begin
                    state_next = S_BOUND;
                end
            end
            S_BOUND: state_next = S_WIN;
            S_WIN: begin
                state_next = stat.empty ? S_DONE : S_BASE;
            end
            S_BASE: state_next = S_SCAN;
            S_SCAN: begin
                if (stat.scan_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_DONE;
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready         = 1'b1;
                cmd.load_pix    = s_valid && s_command == CMD_LOAD;
                cmd.start_query = s_valid && s_command == CMD_QUERY;
            end
            S_BOUND: cmd.bound = 1'b1;
            S_WIN:   cmd.win   = 1'b1;
            S_BASE:  cmd.base  = 1'b1;
            S_SCAN:  cmd.scan  = 1'b1;
            S_DRAIN: ;
            S_DONE:  cmd.push  = stat.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/oigo_dp.sv =====
// Datapath: configuration registers, load position, window bounds, scan
// counters, flag memory and the output register. Uses oigo_pkg, oigo_ram.
`default_nettype none

module oigo_dp
    import oigo_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic [PIX_W-1:0]   s_red,
    input  wire logic [PIX_W-1:0]   s_green,
    input  wire logic [PIX_W-1:0]   s_blue,
    input  wire logic [CELL_W-1:0]  s_cell_row,
    input  wire logic [CELL_W-1:0]  s_cell_col,
    input  wire logic               cfg_wr_en,
    input  wire logic [IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wr_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_occupied
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * DIM_W;
    localparam int CMP_W  = (ADDR_W + 1 > PROD_W) ? ADDR_W + 1 : PROD_W;

    // Configuration registers
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [RAD_W-1:0] radius_reg;
    logic [CSZ_W-1:0] csize_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            radius_reg <= RST_RADIUS;
            csize_reg  <= RST_CSIZE;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_IMAGE_WIDTH:    width_reg  <= cfg_wr_data;
                REG_IMAGE_HEIGHT:   height_reg <= cfg_wr_data;
                REG_INFLATE_RADIUS: radius_reg <= cfg_wr_data[RAD_W-1:0];
                REG_CELL_SIZE:      csize_reg  <= cfg_wr_data[CSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped dimensions and cell size
    logic [DIM_W-1:0]  w, h, wm1, hm1;
    logic [CSZ_W-1:0]  csz;
    logic [PROD_W-1:0] total;

    always_comb begin
        if (width_reg == '0) begin
            w = DIM_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w = DIM_W'(MAX_WIDTH);
        end else begin
            w = width_reg;
        end
        if (height_reg == '0) begin
            h = DIM_W'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h = DIM_W'(MAX_HEIGHT);
        end else begin
            h = height_reg;
        end
        if (csize_reg == '0) begin
            csz = CSZ_W'(1);
        end else if (csize_reg > CELL_MAX) begin
            csz = CELL_MAX;
        end else begin
            csz = csize_reg;
        end
        wm1   = w - DIM_W'(1);
        hm1   = h - DIM_W'(1);
        total = PROD_W'(w) * PROD_W'(h);
    end

    // Load position, wraps at the image size
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] wr_addr;
    logic [CMP_W-1:0]  pos_inc;
    logic [FLAG_W-1:0] wr_flags;

    always_comb begin
        wr_addr  = (CMP_W'(pos_reg) >= CMP_W'(total)) ? '0 : pos_reg;
        pos_inc  = CMP_W'(wr_addr) + CMP_W'(1);
        pos_next = (pos_inc >= CMP_W'(total)) ? '0 : ADDR_W'(pos_inc);
        wr_flags[FLAG_BLACK]   = (s_red == '0) && (s_green == '0) && (s_blue == '0);
        wr_flags[FLAG_NOT_RED] = (s_red != RED_FULL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.load_pix) begin
            pos_reg <= pos_next;
        end
    end

    // Cell origin, cell bounds and window bounds
    logic [COORD_W-1:0] r0_reg, c0_reg;
    logic [DIM_W-1:0]   r1_reg, c1_reg;
    logic [DIM_W-1:0]   row_lo_reg, row_hi_reg, col_lo_reg, col_hi_reg;
    logic               empty_reg;
    logic [COORD_W-1:0] r_end, c_end;
    logic [DIM_W:0]     r_grow, c_grow;

    always_comb begin
        r_end  = r0_reg + COORD_W'(csz) - COORD_W'(1);
        c_end  = c0_reg + COORD_W'(csz) - COORD_W'(1);
        r_grow = (DIM_W+1)'(r1_reg) + (DIM_W+1)'(radius_reg);
        c_grow = (DIM_W+1)'(c1_reg) + (DIM_W+1)'(radius_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_query) begin
            r0_reg <= COORD_W'(s_cell_row) * COORD_W'(csz);
            c0_reg <= COORD_W'(s_cell_col) * COORD_W'(csz);
        end
        if (cmd.bound) begin
            r1_reg    <= (r_end > COORD_W'(hm1)) ? hm1 : DIM_W'(r_end);
            c1_reg    <= (c_end > COORD_W'(wm1)) ? wm1 : DIM_W'(c_end);
            empty_reg <= (r0_reg > COORD_W'(hm1)) || (c0_reg > COORD_W'(wm1));
        end
        if (cmd.win) begin
            row_lo_reg <= (r0_reg > COORD_W'(radius_reg))
                        ? DIM_W'(r0_reg - COORD_W'(radius_reg)) : '0;
            col_lo_reg <= (c0_reg > COORD_W'(radius_reg))
                        ? DIM_W'(c0_reg - COORD_W'(radius_reg)) : '0;
            row_hi_reg <= (r_grow > (DIM_W+1)'(hm1)) ? hm1 : DIM_W'(r_grow);
            col_hi_reg <= (c_grow > (DIM_W+1)'(wm1)) ? wm1 : DIM_W'(c_grow);
        end
    end

    // Window scan counters, row base address tracks row * width
    logic [DIM_W-1:0]  row_reg, col_reg;
    logic [ADDR_W-1:0] row_base_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              row_end, in_cell;

    always_comb begin
        rd_addr = row_base_reg + ADDR_W'(col_reg);
        row_end = (col_reg == col_hi_reg);
        in_cell = (COORD_W'(row_reg) >= r0_reg) && (row_reg <= r1_reg)
               && (COORD_W'(col_reg) >= c0_reg) && (col_reg <= c1_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.base) begin
            row_reg      <= row_lo_reg;
            col_reg      <= col_lo_reg;
            row_base_reg <= ADDR_W'(PROD_W'(row_lo_reg) * PROD_W'(w));
        end else if (cmd.scan) begin
            if (row_end) begin
                col_reg      <= col_lo_reg;
                row_reg      <= row_reg + DIM_W'(1);
                row_base_reg <= row_base_reg + ADDR_W'(w);
            end else begin
                col_reg <= col_reg + DIM_W'(1);
            end
        end
    end

    // Flag memory
    logic [FLAG_W-1:0] rd_flags;

    oigo_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (DEPTH)
    ) u_flags (
        .aclk  (aclk),
        .we    (cmd.load_pix),
        .waddr (wr_addr),
        .wdata (wr_flags),
        .raddr (rd_addr),
        .rdata (rd_flags)
    );

    // Read tag is registered alongside the registered read, aligned with its data
    logic rd_valid_reg, rd_cell_reg;
    logic occ_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.scan;
        end
        rd_cell_reg <= in_cell;
    end

    // Occupancy: red below full inside the cell, or black anywhere in the window
    always_ff @(posedge aclk) begin
        if (cmd.start_query) begin
            occ_reg <= 1'b0;
        end else if (rd_valid_reg) begin
            occ_reg <= occ_reg | rd_flags[FLAG_BLACK]
                     | (rd_cell_reg & rd_flags[FLAG_NOT_RED]);
        end
    end

    // Output register
    logic m_valid_reg, m_occupied_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.push) begin
            m_occupied_reg <= occ_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_occupied = m_occupied_reg;

    // Status
    always_comb begin
        stat.empty     = empty_reg;
        stat.scan_last = row_end && (row_reg == row_hi_reg);
        stat.out_free  = !m_valid_reg || m_ready;
    end

endmodule

`default_nettype wire

// ===== bench/obstacle_inflate_grid_occupancy_core_tb.sv =====
// Self-checking bench for the occupancy grid core with square obstacle inflation.
// Needs oigo_pkg and the core RTL. It loads map images, queries cells and
// checks each occupancy beat against a behavioral copy of the flag store.
`timescale 1ns / 100ps

module obstacle_inflate_grid_occupancy_core_tb;
    import oigo_pkg::*;

    // One input beat: a pixel load or a cell query
    typedef struct {
        logic              cmd;
        logic [PIX_W-1:0]  red;
        logic [PIX_W-1:0]  green;
        logic [PIX_W-1:0]  blue;
        logic [CELL_W-1:0] row;
        logic [CELL_W-1:0] col;
    } beat_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic              s_command = CMD_LOAD;
    logic [PIX_W-1:0]  s_red = '0;
    logic [PIX_W-1:0]  s_green = '0;
    logic [PIX_W-1:0]  s_blue = '0;
    logic [CELL_W-1:0] s_cell_row = '0;
    logic [CELL_W-1:0] s_cell_col = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_occupied;
    logic              cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]  cfg_wr_data = '0;

    // Behavioral copy of the block: flag store, load pointer, effective config
    bit [FLAG_W-1:0] flag_mem [DEF_MAX_WIDTH*DEF_MAX_HEIGHT];
    int load_ptr = 0;
    int img_w = int'(RST_WIDTH);
    int img_h = int'(RST_HEIGHT);
    int rad_px = int'(RST_RADIUS);
    int cell_px = int'(RST_CSIZE);

    beat_t pending_beats [$];
    bit    expected_occupancy [$];
    beat_t cur;
    bit    want_occ;

    int beats_queued = 0;
    int beats_taken = 0;
    int queries_taken = 0;
    int results_seen = 0;
    int fail_cnt = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int budget = 10000;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;

    obstacle_inflate_grid_occupancy_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_cell_row  (s_cell_row),
        .s_cell_col  (s_cell_col),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_occupied  (m_occupied),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    function automatic int clamp_to(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Occupancy of one cell: not-red flag inside the cell, or black flag in the
    // cell grown by the radius, both clipped to the image
    function automatic bit cell_occupied(input logic [CELL_W-1:0] row,
                                         input logic [CELL_W-1:0] col);
        int r0, c0, r1, c1, ra, rb, ca, cb, r, c;
        bit hit;
        hit = 1'b0;
        r0 = int'(row) * cell_px;
        c0 = int'(col) * cell_px;
        r1 = (r0 + cell_px - 1 < img_h - 1) ? r0 + cell_px - 1 : img_h - 1;
        c1 = (c0 + cell_px - 1 < img_w - 1) ? c0 + cell_px - 1 : img_w - 1;
        if (r0 <= r1 && c0 <= c1) begin
            for (r = r0; r <= r1; r++)
                for (c = c0; c <= c1; c++)
                    if (flag_mem[r * img_w + c][FLAG_NOT_RED]) hit = 1'b1;
            ra = (r0 - rad_px > 0) ? r0 - rad_px : 0;
            rb = (r1 + rad_px < img_h - 1) ? r1 + rad_px : img_h - 1;
            ca = (c0 - rad_px > 0) ? c0 - rad_px : 0;
            cb = (c1 + rad_px < img_w - 1) ? c1 + rad_px : img_w - 1;
            for (r = ra; r <= rb; r++)
                for (c = ca; c <= cb; c++)
                    if (flag_mem[r * img_w + c][FLAG_BLACK]) hit = 1'b1;
        end
        return hit;
    endfunction

    // Mostly full-red map with sparse black and not-full-red pixels
    function automatic logic [23:0] pick_pixel();
        int sel;
        sel = $urandom_range(99);
        if (sel < 6) return 24'h000000;
        if (sel < 12) return {8'($urandom_range(254)), 16'($urandom)};
        if (sel < 15) return 24'($urandom);
        return {RED_FULL, 16'($urandom)};
    endfunction

    task automatic queue_load(input logic [23:0] rgb);
        beat_t b;
        b.cmd   = CMD_LOAD;
        b.red   = rgb[23:16];
        b.green = rgb[15:8];
        b.blue  = rgb[7:0];
        b.row   = CELL_W'($urandom);
        b.col   = CELL_W'($urandom);
        pending_beats.push_back(b);
        beats_queued++;
        budget += 20;
    endtask

    task automatic queue_query(input logic [CELL_W-1:0] row, input logic [CELL_W-1:0] col);
        beat_t b;
        int win;
        b.cmd   = CMD_QUERY;
        b.red   = PIX_W'($urandom);
        b.green = PIX_W'($urandom);
        b.blue  = PIX_W'($urandom);
        b.row   = row;
        b.col   = col;
        pending_beats.push_back(b);
        beats_queued++;
        win = (cell_px + 2 * rad_px) * (cell_px + 2 * rad_px);
        if (win > img_w * img_h) win = img_w * img_h;
        budget += 48 + win;
    endtask

    // Write all four registers back to back; only called with the core idle
    task automatic set_config(input int wv, input int hv, input int rv, input int cv);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_IMAGE_WIDTH;
        cfg_wr_data <= CFG_W'(wv);
        @(posedge aclk);
        cfg_index   <= REG_IMAGE_HEIGHT;
        cfg_wr_data <= CFG_W'(hv);
        @(posedge aclk);
        cfg_index   <= REG_INFLATE_RADIUS;
        cfg_wr_data <= CFG_W'(rv);
        @(posedge aclk);
        cfg_index   <= REG_CELL_SIZE;
        cfg_wr_data <= CFG_W'(cv);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        img_w   = clamp_to(wv, DEF_MAX_WIDTH);
        img_h   = clamp_to(hv, DEF_MAX_HEIGHT);
        rad_px  = rv;
        cell_px = clamp_to(cv, int'(CELL_MAX));
        budget += 100;
    endtask

    // Wait until every beat is taken and every query answered, then let
    // trailing loads settle
    task automatic wait_drained();
        do @(posedge aclk);
        while (beats_taken != beats_queued || results_seen != queries_taken);
        repeat (20) @(posedge aclk);
    endtask

    // Driver: present queued beats, update the behavioral copy on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                beats_taken <= beats_taken + 1;
                if (cur.cmd == CMD_QUERY) begin
                    expected_occupancy.push_back(cell_occupied(cur.row, cur.col));
                    queries_taken <= queries_taken + 1;
                end else begin
                    if (load_ptr >= img_w * img_h) load_ptr = 0;
                    flag_mem[load_ptr][FLAG_BLACK] =
                        (cur.red == 0 && cur.green == 0 && cur.blue == 0);
                    flag_mem[load_ptr][FLAG_NOT_RED] = (cur.red != RED_FULL);
                    load_ptr++;
                    if (load_ptr >= img_w * img_h) load_ptr = 0;
                end
            end
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
                cur = pending_beats.pop_front();
                s_valid    <= 1'b1;
                s_command  <= cur.cmd;
                s_red      <= cur.red;
                s_green    <= cur.green;
                s_blue     <= cur.blue;
                s_cell_row <= cur.row;
                s_cell_col <= cur.col;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each occupancy beat, drive m_ready with random stalls
    // and one long hold-off that starts while a result is waiting
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_occupancy.size() == 0) begin
                    $error("occupied: beat with no query pending, got %0d", m_occupied);
                    fail_cnt++;
                end else begin
                    want_occ = expected_occupancy.pop_front();
                    if (m_occupied !== want_occ) begin
                        $error("occupied: expected %0d, got %0d", want_occ, m_occupied);
                        fail_cnt++;
                    end
                end
            end
            if (hold_req && !hold_taken && m_valid) begin
                hold_taken <= 1'b1;
                hold_left  <= 400;
                m_ready    <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 4 * budget) begin
            $display("obstacle_inflate_grid_occupancy_core: mismatch");
            $finish;
        end
    end

    // Stimulus
    initial begin
        int ph, k, wv, hv, rv, cv;
        logic [23:0] rgb;
        logic [CELL_W-1:0] qr, qc;

        repeat (8) @(posedge aclk);
        aresetn   <= 1'b1;
        send_idle <= 27;
        recv_idle <= 52;

        // Reset config: cells beyond the 256x256 image read nothing
        queue_query(8'd255, 8'd255);
        queue_query(8'd64, 8'd0);
        wait_drained();

        // Zero sizes act as one: a single-pixel image
        set_config(0, 0, 15, 0);
        queue_load(24'h000000);
        queue_query(8'd0, 8'd0);
        queue_query(8'd0, 8'd1);
        queue_query(8'd255, 8'd255);
        queue_load({RED_FULL, 16'hFFFF});
        queue_query(8'd0, 8'd0);
        queue_load(24'h000001);
        queue_query(8'd0, 8'd0);
        queue_load({8'h00, 8'h80, 8'h00});
        queue_query(8'd0, 8'd0);
        queue_load({RED_FULL, 16'h0000});
        queue_query(8'd0, 8'd0);
        wait_drained();

        // Oversized width and cell clamp: one row of 256, first 64 loaded.
        // Black at 5 grows into cell 0 only, a pixel with red below full at 36 marks
        // cell 2 but does not grow into cell 1; cells from column 256 on are
        // outside the clamped image
        set_config(511, 1, 6, 31);
        for (k = 0; k < 64; k++) begin
            rgb = {RED_FULL, 16'($urandom)};
            if (k == 5) rgb = 24'h000000;
            if (k == 36) rgb = {8'd254, 16'($urandom)};
            queue_load(rgb);
        end
        for (k = 0; k < 3; k++) queue_query(8'd0, 8'(k));
        queue_query(8'd0, 8'd16);
        queue_query(8'd0, 8'd20);
        queue_query(8'd1, 8'd0);
        queue_query(8'd0, 8'd255);
        wait_drained();

        // Oversized height: one column of 256, loads continue at row 64 so
        // rows 0..127 hold data; rows from 256 on are outside the image
        set_config(1, 511, 3, 16);
        for (k = 0; k < 64; k++) begin
            rgb = {RED_FULL, 16'($urandom)};
            if (k == 8) rgb = 24'h000000;
            if (k == 40) rgb = {8'h00, 8'h05, 8'h00};
            queue_load(rgb);
        end
        for (k = 0; k < 7; k++) queue_query(8'(k), 8'd0);
        queue_query(8'd16, 8'd0);
        queue_query(8'd20, 8'd0);
        queue_query(8'd2, 8'd1);
        wait_drained();

        // Random phases: full image load, then queries mixed with reloads
        for (ph = 0; ph < 6; ph++) begin
            wait_drained();
            if (ph == 2) begin
                send_idle <= 52;
                recv_idle <= 27;
            end else if (ph == 4) begin
                send_idle <= 0;
                recv_idle <= 0;
            end
            if ($urandom_range(9) == 0) wv = 0;
            else wv = $urandom_range(1, 10);
            if ($urandom_range(9) == 0) hv = 0;
            else hv = $urandom_range(1, 8);
            rv = (ph == 0) ? 0 : (ph == 1) ? 15 : $urandom_range(15);
            cv = $urandom_range(31);
            set_config(wv, hv, rv, cv);
            for (k = 0; k < img_w * img_h; k++) queue_load(pick_pixel());
            for (k = 0; k < 16; k++) begin
                if ($urandom_range(3) == 0) begin
                    queue_load(pick_pixel());
                end else begin
                    if ($urandom_range(19) == 0) begin
                        qr = CELL_W'($urandom);
                        qc = CELL_W'($urandom);
                    end else begin
                        qr = CELL_W'($urandom_range((img_h - 1) / cell_px + 1));
                        qc = CELL_W'($urandom_range((img_w - 1) / cell_px + 1));
                    end
                    queue_query(qr, qc);
                end
            end
            // long receiver hold-off while queries keep coming
            if (ph == 3) begin
                hold_req <= 1'b1;
                budget += 600;
            end
        end

        wait_drained();
        repeat (30) @(posedge aclk);
        if (expected_occupancy.size() != 0) begin
            $error("occupied: %0d queries left without a beat", expected_occupancy.size());
            fail_cnt++;
        end
        if (fail_cnt == 0)
            $display("obstacle_inflate_grid_occupancy_core: match");
        else
            $display("obstacle_inflate_grid_occupancy_core: mismatch");
        $finish;
    end

endmodule
